// ===== rtl/sacl_pkg.sv =====
package sacl_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_REPLACE_MODE = 2'd0;
	localparam logic [1:0] REG_OFFSET_BITS  = 2'd1;
	localparam logic [1:0] REG_SET_BITS     = 2'd2;
	localparam logic [1:0] REG_WAYS_IN_USE  = 2'd3;

	localparam logic MODE_LRU  = 1'b0;
	localparam logic MODE_FIFO = 1'b1;

	localparam logic [2:0] AGE_MAX = 3'd7;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} state_t;

endpackage

// ===== rtl/set_assoc_cache_tag_lookup.sv =====
// Set-associative cache tag lookup with LRU or FIFO replacement.
// Input channel: address with valid/ready; one beat is one access.
// Output channel: hit, set_index, line_tag, evicted, evicted_tag and the
// saturating hit and miss counters, with valid/ready; one beat per access.
// Configuration: write enable, index and data; write only while idle.
// Each set is one row of a synchronous memory (all ways side by side).
// An access is accepted, its row read from the set memory (registered read),
// then compared, a victim chosen and the row written back. The next access is
// accepted once the row is written and the output register is free or
// being drained, so a new access is not taken before the last one is written
// back, as set by the read-modify-write of the set memory.
// After reset a clearing pass walks all MAX_SETS rows, one per cycle,
// clearing valid bits, ages and the FIFO pointer; no access is accepted
// during the clearing pass. Counters and registers clear at once.
// If the receiver stalls, the result holds in the output register and
// no new access is accepted until that beat is taken.
module set_assoc_cache_tag_lookup
	import sacl_pkg::*;
#(
	parameter int MAX_SETS = 256,
	parameter int MAX_WAYS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [7:0]  set_index,
	output logic [31:0] line_tag,
	output logic        evicted,
	output logic [31:0] evicted_tag,
	output logic [31:0] hit_count,
	output logic [31:0] miss_count
);

	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);

	typedef struct packed {
		logic [WAY_W-1:0]         fifo;
		logic [MAX_WAYS-1:0]      valid;
		logic [MAX_WAYS-1:0][2:0] age;
		logic [MAX_WAYS-1:0][31:0] tag;
	} row_t;

	// configuration registers
	logic       mode_q;
	logic [3:0] off_q, sbits_q, ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LRU;
			off_q   <= 4'd2;
			sbits_q <= 4'd0;
			ways_q  <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REPLACE_MODE: mode_q  <= cfg_data[0];
				REG_OFFSET_BITS:  off_q   <= cfg_data;
				REG_SET_BITS:     sbits_q <= cfg_data;
				REG_WAYS_IN_USE:  ways_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// address split
	logic [3:0]  off_e, sb_e;
	logic [31:0] set_raw, tag_in;
	logic [4:0]  tshift;
	logic [7:0]  set_mask;

	always_comb begin
		off_e    = (off_q > 4'd8) ? 4'd8 : off_q;
		sb_e     = (sbits_q > 4'd8) ? 4'd8 : sbits_q;
		set_mask = 8'((9'd1 << sb_e) - 9'd1);
		set_raw  = address >> off_e;
		tshift   = 5'(off_e) + 5'(sb_e);
		tag_in   = address >> tshift;
	end

	// set memory
	row_t             mem [MAX_SETS];
	row_t             rd_row;
	logic             mem_we;
	logic [SET_W-1:0] mem_waddr, mem_raddr;
	row_t             mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_row <= mem[mem_raddr];
	end

	state_t           state_q, state_d;
	logic [SET_W-1:0] clr_q;
	logic [SET_W-1:0] set_s1;
	logic [7:0]       seto_s1;
	logic [31:0]      tag_s1;
	logic [31:0]      hits_q, misses_q;

	// effective way count
	logic [WCNT_W-1:0] ways_e;
	always_comb begin
		if (ways_q == 4'd0) ways_e = WCNT_W'(1);
		else if (32'(ways_q) > MAX_WAYS) ways_e = WCNT_W'(MAX_WAYS);
		else ways_e = WCNT_W'(ways_q);
	end

	// lookup, victim choice and row update
	logic             hit_w, free_w, ev_w;
	logic [WAY_W-1:0] slot, free_slot, hit_slot, lru_slot, fifo_p, fifo_n;
	logic [2:0]       old_age, best_age;
	logic [31:0]      ev_tag_w;
	row_t             new_row;

	always_comb begin
		hit_w = 1'b0; hit_slot = '0;
		free_w = 1'b0; free_slot = '0;
		lru_slot = '0; best_age = rd_row.age[0];
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (w < 32'(ways_e)) begin
				if (rd_row.valid[w] && rd_row.tag[w] == tag_s1) begin
					hit_w = 1'b1; hit_slot = WAY_W'(w);
				end
				if (!rd_row.valid[w]) begin
					free_w = 1'b1; free_slot = WAY_W'(w);
				end
			end
		end
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (w < 32'(ways_e) && rd_row.age[w] > best_age) begin
				best_age = rd_row.age[w]; lru_slot = WAY_W'(w);
			end
		end
		fifo_p = (32'(rd_row.fifo) >= 32'(ways_e)) ? '0 : rd_row.fifo;
		fifo_n = (32'(fifo_p) + 1 >= 32'(ways_e)) ? '0 : WAY_W'(32'(fifo_p) + 1);
		new_row = rd_row;
		ev_w = 1'b0;
		if (hit_w) slot = hit_slot;
		else if (free_w) slot = free_slot;
		else begin
			ev_w = 1'b1;
			if (mode_q == MODE_LRU) slot = lru_slot;
			else begin
				slot = fifo_p;
				new_row.fifo = fifo_n;
			end
		end
		ev_tag_w = ev_w ? rd_row.tag[slot] : 32'd0;
		old_age = rd_row.age[slot];
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < 32'(ways_e) && WAY_W'(w) != slot && rd_row.valid[w]) begin
				if ((!rd_row.valid[slot] || rd_row.age[w] < old_age)
					&& rd_row.age[w] < AGE_MAX)
					new_row.age[w] = rd_row.age[w] + 3'd1;
			end
		end
		new_row.age[slot]   = 3'd0;
		new_row.valid[slot] = 1'b1;
		new_row.tag[slot]   = tag_s1;
	end

	logic in_acc, out_acc;
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// control: clear pass, then accept / read / write
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = set_s1;
		mem_wdata = new_row;
		mem_raddr = SET_W'(set_raw[7:0] & set_mask);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (32'(clr_q) == MAX_SETS - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = !out_valid || out_ready;
				if (in_acc) state_d = ST_READ;
			end
			ST_READ: begin
				// row of the accepted set is read here, used in ST_WRITE
				mem_raddr = set_s1;
				state_d   = ST_WRITE;
			end
			ST_WRITE: begin
				mem_we  = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
			hits_q    <= '0;
			misses_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + SET_W'(1);
			if (out_acc) out_valid <= 1'b0;
			if (state_q == ST_WRITE) begin
				out_valid <= 1'b1;
				if (hit_w) begin
					if (hits_q != '1) hits_q <= hits_q + 32'd1;
				end else if (misses_q != '1) misses_q <= misses_q + 32'd1;
			end
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			set_s1  <= mem_raddr;
			seto_s1 <= set_raw[7:0] & set_mask;
			tag_s1  <= tag_in;
		end
		if (state_q == ST_WRITE) begin
			hit         <= hit_w;
			set_index   <= 8'(SET_W'(seto_s1));
			line_tag    <= tag_s1;
			evicted     <= ev_w;
			evicted_tag <= ev_tag_w;
		end
	end

	assign hit_count  = hits_q;
	assign miss_count = misses_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready) else $error("accept during clear");
	a_write_then_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |=> out_valid) else $error("result lost");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE && hit_w |-> !ev_w) else $error("hit with eviction");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_WRITE |=> $stable(hits_q) && $stable(misses_q))
		else $error("counter moved");

endmodule

// ===== tb/sv/set_assoc_cache_tag_lookup_checker.sv =====
module set_assoc_cache_tag_lookup_checker
	import sacl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] address,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        hit,
	input  logic [7:0]  set_index,
	input  logic [31:0] line_tag,
	input  logic        evicted,
	input  logic [31:0] evicted_tag,
	input  logic [31:0] hit_count,
	input  logic [31:0] miss_count,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETS = 256;
	localparam int WAYS = 8;

	typedef struct packed {
		logic        hit;
		logic [7:0]  set_index;
		logic [31:0] line_tag;
		logic        evicted;
		logic [31:0] evicted_tag;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
	} lookup_t;

	// shadow copy of the tag array and registers
	logic        mode_q;
	logic [3:0]  off_q, setw_q, ways_q;
	logic        line_valid [SETS*WAYS];
	logic [31:0] line_tag_m [SETS*WAYS];
	logic [2:0]  line_age   [SETS*WAYS];
	logic [2:0]  fifo_ptr   [SETS];
	logic [31:0] hits_q, misses_q;

	lookup_t lookups_due[$];

	assign pending = lookups_due.size();

	// make way w most recent, age the younger valid ways
	task automatic touch(input int base, input int nways, input int w);
		int old;
		old = line_valid[base+w] ? int'(line_age[base+w]) : 8;
		for (int v = 0; v < nways; v++) begin
			if (v != w && line_valid[base+v] && int'(line_age[base+v]) < old
				&& line_age[base+v] < AGE_MAX)
				line_age[base+v] = line_age[base+v] + 3'd1;
		end
		line_age[base+w] = 3'd0;
	endtask

	task automatic predict_lookup(input logic [31:0] a, output lookup_t r);
		int o, s, nways, set, base, slot, p;
		logic [63:0] tag64;
		logic found, free;
		o = off_q > 8 ? 8 : int'(off_q);
		s = setw_q > 8 ? 8 : int'(setw_q);
		nways = ways_q == 0 ? 1 : (ways_q > WAYS ? WAYS : int'(ways_q));
		set = int'((a >> o) & ((32'd1 << s) - 1)) % SETS;
		tag64 = {32'd0, a} >> (o + s);
		base = set * WAYS;
		found = 0;
		slot = 0;
		r = '0;
		for (int w = 0; w < nways; w++) begin
			if (!found && line_valid[base+w] && line_tag_m[base+w] == tag64[31:0]) begin
				found = 1;
				slot = w;
			end
		end
		if (found) begin
			touch(base, nways, slot);
			if (hits_q != 32'hFFFF_FFFF) hits_q++;
		end else begin
			free = 0;
			for (int w = 0; w < nways; w++) begin
				if (!free && !line_valid[base+w]) begin
					free = 1;
					slot = w;
				end
			end
			if (!free) begin
				if (mode_q == MODE_LRU) begin
					slot = 0;
					for (int w = 1; w < nways; w++)
						if (line_age[base+w] > line_age[base+slot]) slot = w;
				end else begin
					p = int'(fifo_ptr[set]);
					if (p >= nways) p = 0;
					slot = p;
					p++;
					if (p >= nways) p = 0;
					fifo_ptr[set] = 3'(p);
				end
				r.evicted = 1;
				r.evicted_tag = line_tag_m[base+slot];
			end
			touch(base, nways, slot);
			line_valid[base+slot] = 1;
			line_tag_m[base+slot] = tag64[31:0];
			if (misses_q != 32'hFFFF_FFFF) misses_q++;
		end
		r.hit = found;
		r.set_index = 8'(set);
		r.line_tag = tag64[31:0];
		r.hit_count = hits_q;
		r.miss_count = misses_q;
	endtask

	function automatic int field_ok(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, got_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_t r, e;
		if (!arst_n) begin
			mode_q = MODE_LRU;
			off_q = 4'd2;
			setw_q = 4'd0;
			ways_q = 4'd1;
			for (int i = 0; i < SETS*WAYS; i++) begin
				line_valid[i] = 0;
				line_age[i] = 3'd0;
				line_tag_m[i] = 32'd0;
			end
			for (int i = 0; i < SETS; i++) fifo_ptr[i] = 3'd0;
			hits_q = 0;
			misses_q = 0;
			errors = 0;
			lookups_due.delete();
		end else begin
			// result beat: compare with oldest expectation
			if (out_valid && out_ready) begin
				if (lookups_due.size() == 0) begin
					$display("%0t unexpected result beat: expected none actual tag %h",
						$realtime, line_tag);
					errors++;
				end else begin
					e = lookups_due.pop_front();
					errors += field_ok("hit", e.hit, hit)
						+ field_ok("set_index", e.set_index, set_index)
						+ field_ok("line_tag", e.line_tag, line_tag)
						+ field_ok("evicted", e.evicted, evicted)
						+ field_ok("evicted_tag", e.evicted_tag, evicted_tag)
						+ field_ok("hit_count", e.hit_count, hit_count)
						+ field_ok("miss_count", e.miss_count, miss_count);
				end
			end
			// access beat: predict
			if (in_valid && in_ready) begin
				predict_lookup(address, r);
				lookups_due.push_back(r);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_REPLACE_MODE: mode_q = cfg_data[0];
					REG_OFFSET_BITS:  off_q = cfg_data;
					REG_SET_BITS:     setw_q = cfg_data;
					REG_WAYS_IN_USE:  ways_q = cfg_data;
				endcase
			end
		end
	end

endmodule

// ===== tb/sv/set_assoc_cache_tag_lookup_test.sv =====
module set_assoc_cache_tag_lookup_test;
	import sacl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = REG_REPLACE_MODE;
	logic [3:0]  cfg_data = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [31:0] address = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic        hit, evicted;
	logic [7:0]  set_index;
	logic [31:0] line_tag, evicted_tag, hit_count, miss_count;
	int          errors, pending;

	// 0: sender 19% idle, receiver 88%; 1: swapped; 2: no idling
	int idle_mode = 0;
	int accesses_sent = 0;
	int stall_cycles = 0;

	set_assoc_cache_tag_lookup DUT (.*);
	set_assoc_cache_tag_lookup_checker checker_i (.*);

	always #6 clk = ~clk;

	// receiver stalls
	always @(negedge clk) begin
		case (idle_mode)
			0: out_ready = $urandom_range(99) >= 88;
			1: out_ready = $urandom_range(99) >= 19;
			default: out_ready = 1;
		endcase
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else if (++stall_cycles >= STALL_LIMIT) begin
			$display("FAIL set_assoc_cache_tag_lookup");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// one access beat; gaps only while valid is low
	task automatic send_access(input logic [31:0] a);
		@(negedge clk);
		idle_mode = accesses_sent < 570 ? 0 : (accesses_sent < 1140 ? 1 : 2);
		while ((idle_mode == 0 && $urandom_range(99) < 19)
			|| (idle_mode == 1 && $urandom_range(99) < 88)) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		address = a;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		accesses_sent++;
	endtask

	task automatic set_config(input logic m, input logic [3:0] o, input logic [3:0] s,
			input logic [3:0] w);
		@(negedge clk);
		in_valid = 0;
		drain();
		write_reg(REG_REPLACE_MODE, {3'($urandom), m});
		write_reg(REG_OFFSET_BITS, o);
		write_reg(REG_SET_BITS, s);
		write_reg(REG_WAYS_IN_USE, w);
	endtask

	logic [3:0] cfg_tab [12][4] = '{
		'{0, 0, 0, 8}, '{1, 0, 0, 8}, '{0, 8, 8, 1}, '{1, 15, 15, 15},
		'{0, 4, 3, 4}, '{1, 4, 3, 4}, '{0, 3, 2, 0}, '{1, 2, 1, 3},
		'{0, 9, 12, 2}, '{1, 5, 0, 7}, '{0, 1, 4, 8}, '{1, 6, 2, 5}};

	logic [31:0] directed [16] = '{
		32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h4, 32'h3, 32'h0,
		32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
		32'h1, 32'h2, 32'hFFFF_FFFC, 32'h0};

	initial begin
		int o, s, nw, tag_span;
		logic [31:0] tag_base;
		logic [63:0] a;
		repeat (2) @(negedge clk);
		arst_n = 1;

		// reset config: direct mapped, one set
		foreach (directed[i]) send_access(directed[i]);
		// wide fully associative, then eviction on full set
		set_config(MODE_LRU, 0, 0, 8);
		for (int i = 0; i < 9; i++) send_access(32'(i) << 4);
		send_access(32'h0);

		foreach (cfg_tab[p]) begin
			set_config(cfg_tab[p][0][0], cfg_tab[p][1], cfg_tab[p][2], cfg_tab[p][3]);
			o = cfg_tab[p][1] > 8 ? 8 : cfg_tab[p][1];
			s = cfg_tab[p][2] > 8 ? 8 : cfg_tab[p][2];
			nw = cfg_tab[p][3] == 0 ? 1 : (cfg_tab[p][3] > 8 ? 8 : cfg_tab[p][3]);
			tag_span = 2 * nw + 1;
			tag_base = $urandom;
			for (int j = 0; j < 140; j++) begin
				// hold off once until every result is back
				if (p == 5 && j == 70) begin
					@(negedge clk);
					in_valid = 0;
					while (pending != 0) @(negedge clk);
				end
				if ($urandom_range(7) == 0)
					a = {32'd0, $urandom};
				else begin
					a = 64'(tag_base + $urandom_range(tag_span)) << (o + s);
					a |= 64'($urandom_range(3) & ((1 << s) - 1)) << o;
					a |= 64'($urandom & ((1 << o) - 1));
				end
				send_access(a[31:0]);
			end
		end

		@(negedge clk);
		in_valid = 0;
		drain();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("PASS set_assoc_cache_tag_lookup");
		else
			$display("FAIL set_assoc_cache_tag_lookup");
		$finish;
	end

endmodule

// ===== set_assoc_cache_tag_lookup.f =====
rtl/sacl_pkg.sv
rtl/set_assoc_cache_tag_lookup.sv
tb/sv/set_assoc_cache_tag_lookup_checker.sv
tb/sv/set_assoc_cache_tag_lookup_test.sv
